>>> rtl/totp_pkg.sv
// shared types, constants and sha-1 helpers for the totp token generator
package totp_pkg;

  localparam int MaxKeyBytesDef = 24;
  localparam int TimeW          = 63;
  localparam int TokenW         = 27;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 64;
  localparam int CtrW           = 63;
  localparam int IntervalW      = 16;
  localparam int EpochW         = 32;
  localparam int KeyLenW        = 5;
  localparam int DigitW         = 4;
  localparam int QueueDepth     = 2;

  localparam logic [CfgIdxW-1:0] RegKeyLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyMid   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyHigh  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyLen   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEpoch    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInterval = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDigits   = 3'd6;

  localparam logic [7:0]  Ipad       = 8'h36;
  localparam logic [7:0]  Opad       = 8'h5c;
  localparam logic [31:0] OffsetMask = 32'h0000_000f;
  localparam logic [31:0] TruncMask  = 32'h7fff_ffff;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOAD,
    BK_ROUND,
    BK_ADD,
    BK_TRUNC,
    BK_MOD,
    BK_OUT
  } back_state_e;

  // per-item config snapshot travelling with the counter
  typedef struct packed {
    logic [CtrW-1:0] ctr;
    logic [3:0]      digits;
  } job_t;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    rotl1 = {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    rotl5 = {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    rotl30 = {x[1:0], x[31:2]};
  endfunction

  function automatic logic [31:0] sha_k(input logic [6:0] r);
    if (r < 7'd20)      sha_k = 32'h5a827999;
    else if (r < 7'd40) sha_k = 32'h6ed9eba1;
    else if (r < 7'd60) sha_k = 32'h8f1bbcdc;
    else                sha_k = 32'hca62c1d6;
  endfunction

  function automatic logic [31:0] sha_f(input logic [6:0] r, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    if (r < 7'd20)      sha_f = (b & c) | (~b & d);
    else if (r < 7'd40) sha_f = b ^ c ^ d;
    else if (r < 7'd60) sha_f = (b & c) | (b & d) | (c & d);
    else                sha_f = b ^ c ^ d;
  endfunction

endpackage

>>> rtl/totp_front.sv
// front end: takes items, forms the time-step counter by serial division
module totp_front import totp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [TimeW-1:0]     unix_time_i,
  input  logic [EpochW-1:0]    epoch_q_i,
  input  logic [IntervalW-1:0] interval_q_i,
  input  logic [DigitW-1:0]    digits_q_i,
  output logic                 push_o,
  output job_t                 job_o,
  input  logic                 full_i
);

  front_state_e     state_q, state_d;
  logic [CtrW-1:0]  quo_q, quo_d;
  logic [IntervalW-1:0] rem_q, rem_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [IntervalW-1:0] div_q, div_d;
  logic [3:0]       dig_q, dig_d;
  logic [IntervalW:0] trial;

  assign trial = {rem_q, quo_q[CtrW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    dig_q <= dig_d;
  end

  always_comb begin
    state_d    = state_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    div_d      = div_q;
    dig_d      = dig_q;
    in_stall_o = 1'b1;
    push_o     = 1'b0;
    job_o.ctr    = quo_q;
    job_o.digits = dig_q;
    case (state_q)
      FR_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          // time before the epoch saturates to a zero counter
          quo_d = (unix_time_i < {31'd0, epoch_q_i}) ? '0
                : unix_time_i - {31'd0, epoch_q_i};
          rem_d = '0;
          cnt_d = 6'(CtrW);
          div_d = (interval_q_i == '0) ? IntervalW'(1) : interval_q_i;
          if (digits_q_i < 4'd6)      dig_d = 4'd6;
          else if (digits_q_i > 4'd8) dig_d = 4'd8;
          else                        dig_d = digits_q_i;
          state_d = FR_DIV;
        end
      end
      FR_DIV: begin
        // restoring division, one quotient bit per cycle
        if (trial >= {1'b0, div_q}) begin
          rem_d = IntervalW'(trial - {1'b0, div_q});
          quo_d = {quo_q[CtrW-2:0], 1'b1};
        end else begin
          rem_d = trial[IntervalW-1:0];
          quo_d = {quo_q[CtrW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = FR_PUSH;
      end
      FR_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> !full_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FR_DIV) |-> (cnt_q != 6'd0))
    else $error("divider count underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (dig_q >= 4'd6 && dig_q <= 4'd8))
    else $error("digit count out of range");

endmodule

>>> rtl/totp_queue.sv
// short fifo of counter jobs between front and back
module totp_queue import totp_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("push lost");

endmodule

>>> rtl/totp_back.sv
// back end: hmac-sha1 over four blocks, truncation and serial modulo
module totp_back import totp_pkg::*; #(
  parameter int MaxKeyBytes = MaxKeyBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  job_t              job_i,
  output logic              pop_o,
  input  logic [63:0]       key_low_i,
  input  logic [63:0]       key_mid_i,
  input  logic [63:0]       key_high_i,
  input  logic [KeyLenW-1:0] key_len_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TokenW-1:0] token_o
);

  localparam int KlW = (MaxKeyBytes > 31) ? 7 : 6;

  back_state_e  state_q, state_d;
  logic [1:0]   blk_q, blk_d;          // 0 inner key, 1 inner msg, 2 outer key, 3 outer msg
  logic [6:0]   rnd_q, rnd_d;
  logic [31:0]  w_q [16];
  logic [31:0]  w_d [16];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q, a_d, b_d, c_d, d_d, e_d;
  logic [159:0] h_q, h_d, inner_q, inner_d;
  job_t         job_q, job_d;
  logic [58:0]  rem_q, rem_d;          // modulo work: remainder shifted left
  logic [5:0]   mcnt_q, mcnt_d;
  logic [26:0]  mod_q, mod_d;
  logic [TokenW-1:0] tok_q, tok_d;
  logic         ov_q, ov_d;

  logic [KlW-1:0] klen;
  logic [511:0]   blk_data;
  logic [31:0]    wnew, tmp;
  logic [31:0]    p;
  logic [3:0]     off;
  logic [159:0]   hsum;
  logic [191:0]   keyall;

  assign klen   = (key_len_i > KeyLenW'(MaxKeyBytes > 31 ? 31 : MaxKeyBytes))
                ? KlW'(MaxKeyBytes) : KlW'(key_len_i);
  assign keyall = {key_low_i, key_mid_i, key_high_i};

  // assemble the 64-byte block for the current compression
  always_comb begin
    blk_data = '0;
    for (int i = 0; i < 64; i++) begin
      logic [7:0] kb;
      kb = 8'd0;
      if (i < 24 && i < MaxKeyBytes && KlW'(i) < klen) kb = keyall[191-8*i -: 8];
      if (blk_q == 2'd0) blk_data[511-8*i -: 8] = kb ^ Ipad;
      else if (blk_q == 2'd2) blk_data[511-8*i -: 8] = kb ^ Opad;
    end
    if (blk_q == 2'd1) begin
      blk_data = {1'b0, job_q.ctr, 8'h80, 376'd0, 64'd576};
    end else if (blk_q == 2'd3) begin
      blk_data = {inner_q, 8'h80, 280'd0, 64'd672};
    end
  end

  assign wnew = (rnd_q < 7'd16) ? w_q[0]
              : rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);
  assign tmp  = rotl5(a_q) + sha_f(rnd_q, b_q, c_q, d_q) + e_q + sha_k(rnd_q) + wnew;
  assign hsum = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
                 h_q[63:32] + d_q, h_q[31:0] + e_q};
  assign off  = h_q[3:0];
  assign p    = h_q[159 - 8*off -: 32] & TruncMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d; rnd_q <= rnd_d; w_q <= w_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
    h_q <= h_d; inner_q <= inner_d; job_q <= job_d;
    rem_q <= rem_d; mcnt_q <= mcnt_d; mod_q <= mod_d; tok_q <= tok_d;
  end

  always_comb begin
    state_d = state_q; blk_d = blk_q; rnd_d = rnd_q; w_d = w_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    h_d = h_q; inner_d = inner_q; job_d = job_q;
    rem_d = rem_q; mcnt_d = mcnt_q; mod_d = mod_q; tok_d = tok_q; ov_d = ov_q;
    pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          blk_d   = 2'd0;
          h_d     = 160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;
          state_d = BK_LOAD;
        end
      end
      BK_LOAD: begin
        for (int i = 0; i < 16; i++) w_d[i] = blk_data[511-32*i -: 32];
        {a_d, b_d, c_d, d_d, e_d} = h_q;
        rnd_d   = '0;
        state_d = BK_ROUND;
      end
      BK_ROUND: begin
        // 16-word schedule window slides one word per round
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = wnew;
        e_d = d_q; d_d = c_q; c_d = rotl30(b_q); b_d = a_q; a_d = tmp;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'd79) state_d = BK_ADD;
      end
      BK_ADD: begin
        h_d = hsum;
        if (blk_q == 2'd1) begin
          inner_d = hsum;
          h_d     = 160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;
        end
        blk_d = blk_q + 2'd1;
        if (blk_q == 2'd3) state_d = BK_TRUNC;
        else               state_d = BK_LOAD;
      end
      BK_TRUNC: begin
        case (job_q.digits)
          4'd7:    mod_d = 27'd10000000;
          4'd8:    mod_d = 27'd100000000;
          default: mod_d = 27'd1000000;
        endcase
        rem_d   = {27'd0, p};
        mcnt_d  = 6'd32;
        state_d = BK_MOD;
      end
      BK_MOD: begin
        // restoring remainder: rem_q[58:32] partial remainder, [31:0] dividend
        begin
          logic [27:0] tr;
          tr = {rem_q[58:32], rem_q[31]};
          if (tr >= {1'b0, mod_q}) rem_d = {27'(tr - {1'b0, mod_q}), rem_q[30:0], 1'b0};
          else                     rem_d = {tr[26:0], rem_q[30:0], 1'b0};
        end
        mcnt_d = mcnt_q - 6'd1;
        if (mcnt_q == 6'd1) state_d = BK_OUT;
      end
      BK_OUT: begin
        tok_d   = rem_q[58:32];
        ov_d    = 1'b1;
        state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
    if (ov_q && !out_stall_i) ov_d = (state_q == BK_OUT);
    if (state_q == BK_IDLE && ov_q && out_stall_i) begin
      pop_o   = 1'b0;
      state_d = BK_IDLE;
      job_d   = job_q;
      h_d     = h_q;
    end
  end

  assign out_valid_o = ov_q;
  assign token_o     = tok_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (token_o < 27'd100000000))
    else $error("token out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ROUND) |-> (rnd_q < 7'd80))
    else $error("round count overflow");

endmodule

>>> rtl/totp_token_generator.sv
// top level: totp token generator with config registers
// pipeline: accept, serial division, push, pop, then four sha-1 compressions
// (load, 80 rounds, add each), then truncation, modulo and output
// throughput is set by the single sha-1 round unit in the back end, one job at a time
// front and back overlap through a 2-entry job queue
// reset: asynchronous active low; registers take their documented reset values
module totp_token_generator import totp_pkg::*; #(
  parameter int MaxKeyBytes = MaxKeyBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [TimeW-1:0]    unix_time_i,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [TokenW-1:0]   token_o,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [63:0]          key_low_q, key_mid_q, key_high_q;
  logic [KeyLenW-1:0]   key_len_q;
  logic [EpochW-1:0]    epoch_q;
  logic [IntervalW-1:0] interval_q;
  logic [DigitW-1:0]    digits_q;

  logic push, full, pop, empty;
  job_t job_in, job_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_mid_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= KeyLenW'(20);
      epoch_q    <= '0;
      interval_q <= IntervalW'(30);
      digits_q   <= DigitW'(6);
    end else if (cfg_valid) begin
      case (cfg_index_i)
        RegKeyLow:   key_low_q  <= cfg_data_i;
        RegKeyMid:   key_mid_q  <= cfg_data_i;
        RegKeyHigh:  key_high_q <= cfg_data_i;
        RegKeyLen:   key_len_q  <= cfg_data_i[KeyLenW-1:0];
        RegEpoch:    epoch_q    <= cfg_data_i[EpochW-1:0];
        RegInterval: interval_q <= cfg_data_i[IntervalW-1:0];
        RegDigits:   digits_q   <= cfg_data_i[DigitW-1:0];
        default: ;
      endcase
    end
  end

  totp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .unix_time_i,
    .epoch_q_i(epoch_q), .interval_q_i(interval_q), .digits_q_i(digits_q),
    .push_o(push), .job_o(job_in), .full_i(full)
  );

  totp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(job_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(job_out)
  );

  totp_back #(.MaxKeyBytes(MaxKeyBytes)) u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .job_i(job_out), .pop_o(pop),
    .key_low_i(key_low_q), .key_mid_i(key_mid_q), .key_high_i(key_high_q),
    .key_len_i(key_len_q),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .token_o
  );

endmodule

>>> sim/totp_token_checker.sv
// token checker: watches all channels, predicts each token and compares
`timescale 1ns / 1ps
module totp_token_checker import totp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [TimeW-1:0]    unix_time_i,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [TokenW-1:0]   token_o,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  err_cnt_o,
  output int                  pending_cnt_o
);

  logic [63:0] key_lo, key_mid, key_hi;
  logic [4:0]  key_len;
  logic [31:0] epoch;
  logic [15:0] interval;
  logic [3:0]  digits;

  logic [TokenW-1:0] token_q[$];
  logic [7:0]        msg_buf[128];
  int                err_cnt;

  assign err_cnt_o     = err_cnt;
  assign pending_cnt_o = token_q.size();

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

  // sha-1 over msg_buf[0 .. len-1], pads in place
  function automatic logic [159:0] sha_digest(input int len);
    logic [31:0] h[5];
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    logic [63:0] bits;
    int          total;
    total = (len + 9 <= 64) ? 64 : 128;
    for (int i = len; i < 128; i++) msg_buf[i] = 8'h00;
    msg_buf[len] = 8'h80;
    bits = 64'(len) * 8;
    for (int i = 0; i < 8; i++) msg_buf[total - 1 - i] = bits[8*i +: 8];
    h[0] = 32'h67452301; h[1] = 32'hefcdab89; h[2] = 32'h98badcfe;
    h[3] = 32'h10325476; h[4] = 32'hc3d2e1f0;
    for (int blk = 0; blk < total; blk += 64) begin
      for (int i = 0; i < 16; i++)
        w[i] = {msg_buf[blk+4*i], msg_buf[blk+4*i+1], msg_buf[blk+4*i+2], msg_buf[blk+4*i+3]};
      for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d); k = 32'h5a827999;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = 32'h6ed9eba1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc;
        end else begin
          f = b ^ c ^ d; k = 32'hca62c1d6;
        end
        tmp = rol(a, 5) + f + e + k + w[i];
        e = d; d = c; c = rol(b, 30); b = a; a = tmp;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    end
    return {h[0], h[1], h[2], h[3], h[4]};
  endfunction

  function automatic logic [TokenW-1:0] predict_token(input logic [TimeW-1:0] t);
    logic [63:0]  step_ctr;
    logic [191:0] key_all;
    logic [7:0]   kbyte;
    logic [159:0] inner, outer;
    logic [31:0]  p, modulus;
    int           klen, ndig, off;
    step_ctr = (64'(t) < 64'(epoch)) ? 64'd0
             : (64'(t) - 64'(epoch)) / ((interval == 0) ? 64'd1 : 64'(interval));
    klen = (key_len > 24) ? 24 : key_len;
    ndig = (digits < 6) ? 6 : ((digits > 8) ? 8 : digits);
    key_all = {key_lo, key_mid, key_hi};
    for (int i = 0; i < 64; i++) begin
      kbyte = (i < klen) ? key_all[191 - 8*i -: 8] : 8'h00;
      msg_buf[i] = kbyte ^ Ipad;
    end
    for (int i = 0; i < 8; i++) msg_buf[64 + i] = step_ctr[63 - 8*i -: 8];
    inner = sha_digest(72);
    for (int i = 0; i < 64; i++) begin
      kbyte = (i < klen) ? key_all[191 - 8*i -: 8] : 8'h00;
      msg_buf[i] = kbyte ^ Opad;
    end
    for (int i = 0; i < 20; i++) msg_buf[64 + i] = inner[159 - 8*i -: 8];
    outer = sha_digest(84);
    // dynamic truncation from the low nibble of the last digest byte
    off = outer[3:0];
    p = outer[159 - 8*off -: 32] & TruncMask;
    modulus = 1;
    for (int i = 0; i < ndig; i++) modulus *= 10;
    return TokenW'(p % modulus);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo   <= '0;
      key_mid  <= '0;
      key_hi   <= '0;
      key_len  <= 5'd20;
      epoch    <= '0;
      interval <= 16'd30;
      digits   <= 4'd6;
      err_cnt  <= 0;
      token_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_i)
          RegKeyLow:   key_lo   <= cfg_data_i;
          RegKeyMid:   key_mid  <= cfg_data_i;
          RegKeyHigh:  key_hi   <= cfg_data_i;
          RegKeyLen:   key_len  <= cfg_data_i[4:0];
          RegEpoch:    epoch    <= cfg_data_i[31:0];
          RegInterval: interval <= cfg_data_i[15:0];
          RegDigits:   digits   <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) token_q.push_back(predict_token(unix_time_i));
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          $error("token: unexpected item, actual %0d", token_o);
          err_cnt <= err_cnt + 1;
        end else begin
          if (token_o !== token_q[0]) begin
            $error("token: expected %0d actual %0d", token_q[0], token_o);
            err_cnt <= err_cnt + 1;
          end
          void'(token_q.pop_front());
        end
      end
    end
  end

endmodule

>>> sim/totp_token_generator_tb.sv
// testbench top for the totp token generator: stimulus, reset and verdict
`timescale 1ns / 1ps
module totp_token_generator_tb;
  import totp_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int LongHold   = 3000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  logic [TimeW-1:0]    unix_time_i;
  logic                out_valid;
  logic                out_stall;
  logic [TokenW-1:0]   token_o;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  err_cnt;
  int                  pending_cnt;

  bit          quiet;      // no idling on either side
  bit          hold_req;   // receiver holds off for a long stretch
  logic [31:0] cur_epoch;

  totp_token_generator u_dut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .unix_time_i, .out_valid, .out_stall,
    .token_o, .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i
  );

  totp_token_checker u_checker (
    .clk_i, .rst_ni, .in_valid, .in_stall, .unix_time_i, .out_valid, .out_stall,
    .token_o, .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i,
    .err_cnt_o(err_cnt), .pending_cnt_o(pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // token receiver
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 7);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk_i);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == RegEpoch) cur_epoch = data[31:0];
  endtask

  // valid stays high into the next item when no gap is drawn
  task automatic send_time(input logic [TimeW-1:0] t);
    int n;
    n = quiet ? 0 : $urandom_range(0, 7);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    unix_time_i <= t;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  function automatic logic [TimeW-1:0] pick_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return r[62:0];
      1: return 63'(cur_epoch) + 63'($urandom_range(0, 200000));
      2: return 63'($urandom);
      default: return (cur_epoch > 5) ? 63'(cur_epoch - $urandom_range(0, 5)) : 63'd0;
    endcase
  endfunction

  initial begin
    logic [63:0] r;
    in_valid    = 1'b0;
    unix_time_i = '0;
    cfg_valid   = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    cur_epoch   = '0;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: all-zero key of length 20
    send_time(63'd0);
    send_time(63'd59);
    drain();

    // published sha-1 test key, 8 digits
    reg_write(RegKeyLow,  64'h3132333435363738);
    reg_write(RegKeyMid,  64'h3930313233343536);
    reg_write(RegKeyHigh, 64'h3738393000000000);
    reg_write(RegDigits,  64'd8);
    send_time(63'd59);
    send_time(63'd1111111109);
    send_time(63'd1111111111);
    send_time(63'd1234567890);
    send_time(63'd2000000000);
    send_time(63'd20000000000);
    send_time({TimeW{1'b1}});
    drain();

    // time before epoch, zero interval, overlong key length, too few digits
    reg_write(RegEpoch,    64'hffff_ffff);
    reg_write(RegInterval, 64'd0);
    reg_write(RegKeyLen,   64'd31);
    reg_write(RegDigits,   64'd3);
    send_time(63'd0);
    send_time(63'hffff_fffe);
    send_time(63'hffff_ffff);
    send_time(63'h1_0000_0000);
    send_time({TimeW{1'b1}});
    drain();

    // widest interval, empty key, too many digits, write to an unused index
    reg_write(RegInterval, 64'd65535);
    reg_write(RegKeyLen,   64'd0);
    reg_write(RegDigits,   64'd15);
    reg_write(3'd7,        64'hffff_ffff_ffff_ffff);
    reg_write(RegEpoch,    64'd0);
    send_time(63'd65534);
    send_time(63'd65535);
    send_time({TimeW{1'b1}});
    send_time(63'h2aaa_aaaa_aaaa_aaaa);
    send_time(63'h5555_5555_5555_5555);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      r = {$urandom, $urandom}; reg_write(RegKeyLow, (ph == 1) ? '1 : r);
      r = {$urandom, $urandom}; reg_write(RegKeyMid, (ph == 1) ? '1 : r);
      r = {$urandom, $urandom}; reg_write(RegKeyHigh, (ph == 1) ? '1 : r);
      reg_write(RegKeyLen, (ph == 1) ? 64'd24 : 64'($urandom_range(0, 24)));
      case (ph % 3)
        0: reg_write(RegEpoch, 64'($urandom));
        1: reg_write(RegEpoch, 64'd0);
        default: reg_write(RegEpoch, 64'hffff_ffff);
      endcase
      case (ph % 4)
        0: reg_write(RegInterval, 64'd1);
        1: reg_write(RegInterval, 64'd65535);
        default: reg_write(RegInterval, 64'($urandom_range(1, 65535)));
      endcase
      reg_write(RegDigits, 64'($urandom_range(6, 8)));
      quiet = (ph == 4);
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < 43; i++) send_time(pick_time());
      drain();
    end

    repeat (500) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/totp_pkg.sv
rtl/totp_front.sv
rtl/totp_queue.sv
rtl/totp_back.sv
rtl/totp_token_generator.sv
sim/totp_token_checker.sv
sim/totp_token_generator_tb.sv
